@@ rtl/core/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared constants, command and status codes, and the bit search helper.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Default number of pages the map can hold.
  localparam int MAX_PAGES_DEF = 32768;

  // Map word width and the width of page pointers and counts.
  localparam int WORD_W = 8;
  localparam int PTR_W  = 16;

  // Page total after reset.
  localparam logic [PTR_W-1:0] RST_TOTAL = 16'h8000;

  // Command codes.
  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_MARK    = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Lowest clear bit of a map word: bit 3 is the found flag, bits 2:0 the index.
  function automatic logic [3:0] first_zero(input logic [WORD_W-1:0] w);
    logic       found;
    logic [2:0] idx;
    found = 1'b0;
    idx   = 3'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        found = 1'b1;
        idx   = 3'(i);
      end
    end
    return {found, idx};
  endfunction

endpackage

@@ rtl/core/pba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/page_bitmap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Page bitmap allocator
// Keeps a used map of one bit per page in a word RAM, a free page count and
// a first-free pointer; serves alloc, mark, release, query and clear commands.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | command, page_number
//  out      | out_valid / out_ready| result_page, page_used, status, pages_free
//  cfg      | cfg_valid / cfg_ready| cfg_data (total_pages)
//
// Mark, release and query pass through the accept state, a RAM read, an
// evaluate and write-back state and a state that hands over the result.
// Pages beyond the total and unused commands go straight to the result.
// Alloc reads and evaluates each map word visited by the search for the granted
// page and again by the search for the next free page.
// Clear writes every map word (DEPTH words) before handing over the result.
// After reset the map RAM is swept to zero with in_ready low; configuration
// writes are taken at all times. A stalled output holds the
// finished result, and the next transaction is taken while it waits.
module page_bitmap_allocator_top
  import pba_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [14:0] page_number,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] result_page,
  output logic        page_used,
  output logic [1:0]  status,
  output logic [15:0] pages_free,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0]  RST_FREE  =
    (MAX_PAGES < 32768) ? PTR_W'(MAX_PAGES) : RST_TOTAL;

  // State codes.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        cmd;
  logic              phase;       // alloc: 0 searching grant, 1 searching next free
  logic              clr_cmd;     // sweep was started by a clear command
  logic [ADDR_W-1:0] clr_addr;
  logic [PTR_W-1:0]  scan_page;
  logic [PTR_W-1:0]  total_pages;
  logic [PTR_W-1:0]  free_count;
  logic [PTR_W-1:0]  first_free;
  logic [14:0]       res_page;
  logic              res_used;
  logic [1:0]        res_status;

  // Effective page total.
  logic [PTR_W-1:0] total;
  always_comb begin
    if ({16'd0, total_pages} < 32'(MAX_PAGES)) begin
      total = total_pages;
    end else begin
      total = PTR_W'(MAX_PAGES);
    end
  end

  // Map RAM.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  pba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign ram_rd_addr = ADDR_W'(scan_page[PTR_W-1:3]);

  // Word evaluation: search for a clear bit at or above the scan offset.
  logic [WORD_W-1:0] low_mask;
  logic [WORD_W-1:0] masked;
  logic [3:0]        fz;
  logic [PTR_W-1:0]  cand;
  logic [PTR_W:0]    cand_inc;
  logic [PTR_W:0]    next_word_page;
  logic              cand_ok;
  logic              more_words;
  logic [WORD_W-1:0] bit_sel;
  logic [WORD_W-1:0] grant_sel;
  logic              cur_bit;

  always_comb begin
    low_mask       = (WORD_W'(1) << scan_page[2:0]) - WORD_W'(1);
    masked         = ram_rd_data | low_mask;
    fz             = first_zero(masked);
    cand           = {scan_page[PTR_W-1:3], fz[2:0]};
    cand_inc       = {1'b0, cand} + 17'd1;
    next_word_page = {1'b0, scan_page[PTR_W-1:3], 3'b000} + 17'd8;
    cand_ok        = fz[3] && (cand < total);
    more_words     = !fz[3] && (next_word_page < {1'b0, total});
    bit_sel        = WORD_W'(1) << scan_page[2:0];
    grant_sel      = WORD_W'(1) << fz[2:0];
    cur_bit        = ram_rd_data[scan_page[2:0]];
  end

  // Write port: clearing sweep, or write-back of a modified word.
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = ram_rd_addr;
    ram_wr_data = ram_rd_data;
    if (state == S_CLEAR) begin
      ram_we      = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else if (state == S_EV) begin
      if (cmd == CMD_ALLOC && !phase && cand_ok) begin
        ram_we      = 1'b1;
        ram_wr_data = ram_rd_data | grant_sel;
      end else if (cmd == CMD_MARK && !cur_bit) begin
        ram_we      = 1'b1;
        ram_wr_data = ram_rd_data | bit_sel;
      end else if (cmd == CMD_RELEASE && cur_bit) begin
        ram_we      = 1'b1;
        ram_wr_data = ram_rd_data & ~bit_sel;
      end
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= RST_TOTAL;
    end else if (cfg_valid && cfg_ready) begin
      total_pages <= cfg_data;
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cmd    <= 1'b0;
      clr_addr   <= '0;
      free_count <= RST_FREE;
      first_free <= '0;
      phase      <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            if (clr_cmd) begin
              free_count <= total;
              first_free <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            cmd      <= command;
            phase    <= 1'b0;
            res_used <= 1'b0;
            if (command == CMD_ALLOC) begin
              scan_page <= first_free;
              if (first_free >= total) begin
                first_free <= total;
                res_page   <= '0;
                res_status <= ST_OOM;
                state      <= S_DONE;
              end else begin
                res_page   <= page_number;
                res_status <= ST_OK;
                state      <= S_RD;
              end
            end else if (command == CMD_MARK || command == CMD_RELEASE ||
                         command == CMD_QUERY) begin
              scan_page <= {1'b0, page_number};
              res_page  <= page_number;
              if ({1'b0, page_number} >= total) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_RD;
              end
            end else if (command == CMD_CLEAR) begin
              scan_page  <= {1'b0, page_number};
              res_page   <= '0;
              res_status <= ST_OK;
              clr_cmd    <= 1'b1;
              clr_addr   <= '0;
              state      <= S_CLEAR;
            end else begin
              scan_page  <= {1'b0, page_number};
              res_page   <= page_number;
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          end
        end

        S_RD: begin
          state <= S_EV;
        end

        S_EV: begin
          if (cmd == CMD_ALLOC) begin
            if (cand_ok) begin
              if (!phase) begin
                // Grant this page, then look for the next free one.
                res_page <= cand[14:0];
                res_used <= 1'b1;
                if (free_count != '0) begin
                  free_count <= free_count - PTR_W'(1);
                end
                if (cand_inc >= {1'b0, total}) begin
                  first_free <= total;
                  state      <= S_DONE;
                end else begin
                  scan_page <= cand_inc[PTR_W-1:0];
                  phase     <= 1'b1;
                  state     <= S_RD;
                end
              end else begin
                first_free <= cand;
                state      <= S_DONE;
              end
            end else if (more_words) begin
              scan_page <= next_word_page[PTR_W-1:0];
              state     <= S_RD;
            end else begin
              // No clear page below the total.
              first_free <= total;
              if (!phase) begin
                res_page   <= '0;
                res_status <= ST_OOM;
              end
              state <= S_DONE;
            end
          end else begin
            if (cmd == CMD_MARK) begin
              res_used <= 1'b1;
              if (!cur_bit && free_count != '0) begin
                free_count <= free_count - PTR_W'(1);
              end
            end else if (cmd == CMD_RELEASE) begin
              if (cur_bit && free_count != 16'hFFFF) begin
                free_count <= free_count + PTR_W'(1);
              end
              if (scan_page < first_free) begin
                first_free <= scan_page;
              end
            end else begin
              res_used <= cur_bit;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          clr_cmd <= 1'b0;
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      result_page <= res_page;
      page_used   <= res_used;
      status      <= res_status;
      pages_free  <= free_count;
    end
  end

endmodule

@@ rtl/core/pba_checker.sv @@
// ----------------------------------------------------------------------------
// Page bitmap allocator port checker
// Watches the top level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module pba_checker
  import pba_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] result_page,
  input logic        page_used,
  input logic [1:0]  status
);

  // An out of memory result grants nothing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OOM |-> result_page == '0 && !page_used)
    else $error("out of memory result carries a page");

  // A page beyond the total never reads as used.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> !page_used)
    else $error("out of range result shows a used page");

  // The block works on one transaction at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_page) && $stable(status))
    else $error("stalled result changed");

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_page (result_page),
  .page_used   (page_used),
  .status      (status)
);

@@ test/page_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Drives command transactions into the allocator and keeps its own copy of
// the used map, free count, first-free pointer and page total. Each result
// transaction is compared field by field with the oldest outstanding one.
// Directed tests cover reset state, single page operations, running out of
// pages and the extremes of the page total; random phases follow.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top_tb;
  import pba_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 51;

  // Command codes the block treats as no-ops.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [14:0] page;
  } page_command_t;

  typedef struct packed {
    logic [14:0] page;
    logic        used;
    logic [1:0]  code;
    logic [15:0] free;
  } page_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = CMD_ALLOC;
  logic [14:0] page_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] result_page;
  logic        page_used;
  logic [1:0]  status;
  logic [15:0] pages_free;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Mirror of the allocator state.
  bit          page_map [MAX_PAGES_DEF];
  logic [15:0] free_page_count;
  int          first_free_page;
  logic [15:0] total_pages_reg;

  page_command_t commands_waiting [$];
  page_result_t  page_reports_due [$];
  page_command_t queued_command;
  page_result_t  oldest_report;

  int   accepted_items = 0;
  int   issued_items   = 0;
  int   send_gap       = 0;
  int   idle_cycles    = 0;
  int   mismatch_count = 0;
  bit   idle_on        = 1'b1;
  event command_taken;

  page_bitmap_allocator_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .page_number (page_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_page (result_page),
    .page_used   (page_used),
    .status      (status),
    .pages_free  (pages_free),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The page total in effect is capped at the map size.
  function automatic int managed_pages();
    return (total_pages_reg < MAX_PAGES_DEF) ? int'(total_pages_reg) : MAX_PAGES_DEF;
  endfunction

  // First clear page at or after start, or the limit if there is none.
  function automatic int first_clear_from(input int start, input int limit);
    int p;
    p = start;
    while (p < limit && page_map[p]) p++;
    return (p < limit) ? p : limit;
  endfunction

  // Applies one command to the mirrored state and returns the result it causes.
  function automatic page_result_t allocator_step(input logic [2:0] cmd,
                                                  input logic [14:0] pg);
    page_result_t r;
    int           total;
    int           grant;
    total  = managed_pages();
    r.page = pg;
    r.used = 1'b0;
    r.code = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        grant = first_clear_from(first_free_page, total);
        if (grant >= total) begin
          first_free_page = total;
          r.page          = '0;
          r.code          = ST_OOM;
        end else begin
          page_map[grant] = 1'b1;
          if (free_page_count != 16'd0) free_page_count--;
          first_free_page = first_clear_from(grant + 1, total);
          r.page          = 15'(grant);
          r.used          = 1'b1;
        end
      end
      CMD_MARK, CMD_RELEASE, CMD_QUERY: begin
        if (int'(pg) >= total) begin
          r.code = ST_RANGE;
        end else if (cmd == CMD_MARK) begin
          if (!page_map[pg]) begin
            page_map[pg] = 1'b1;
            if (free_page_count != 16'd0) free_page_count--;
          end
          r.used = 1'b1;
        end else if (cmd == CMD_RELEASE) begin
          if (page_map[pg]) begin
            page_map[pg] = 1'b0;
            if (free_page_count != 16'hFFFF) free_page_count++;
          end
          if (int'(pg) < first_free_page) first_free_page = pg;
        end else begin
          r.used = page_map[pg];
        end
      end
      CMD_CLEAR: begin
        page_map        = '{default: 1'b0};
        free_page_count = 16'(total);
        first_free_page = 0;
        r.page          = '0;
      end
      default: begin
      end
    endcase
    r.free = free_page_count;
    return r;
  endfunction

  task automatic report_error(input string what, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  task automatic compare_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    if (got_v !== want_v) report_error(what, want_v, got_v);
  endtask

  // Rising edge: record accepted transactions, check results, run the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) total_pages_reg = cfg_data;
      if (in_valid && in_ready) begin
        page_reports_due.push_back(allocator_step(command, page_number));
        accepted_items++;
        -> command_taken;
      end
      if (out_valid && out_ready) begin
        if (page_reports_due.size() == 0) begin
          report_error("outstanding result count", 16'd1, 16'd0);
        end else begin
          oldest_report = page_reports_due.pop_front();
          compare_field("result_page", 16'(oldest_report.page), 16'(result_page));
          compare_field("page_used", 16'(oldest_report.used), 16'(page_used));
          compare_field("status", 16'(oldest_report.code), 16'(status));
          compare_field("pages_free", oldest_report.free, pages_free);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Falling edge: hold the current transaction until taken, then present the
  // next one or drop valid, with occasional idle bursts in between.
  always @(negedge clk) begin
    if (in_valid && accepted_items != issued_items) begin
      // Current transaction still waiting.
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (commands_waiting.size() != 0) begin
      queued_command = commands_waiting.pop_front();
      command     <= queued_command.cmd;
      page_number <= queued_command.page;
      in_valid    <= 1'b1;
      issued_items++;
      if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side backpressure in random bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Queues one command and returns once the block has taken it.
  task automatic send_command(input logic [2:0] cmd, input logic [14:0] pg);
    page_command_t c;
    c.cmd  = cmd;
    c.page = pg;
    commands_waiting.push_back(c);
    @(command_taken);
  endtask

  // Waits until every result has come back and the block has settled.
  task automatic wait_drained();
    while (commands_waiting.size() != 0 || page_reports_due.size() != 0 ||
           accepted_items != issued_items)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the page total while the block is idle.
  task automatic write_total(input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-range traffic weighted toward alloc, with some noise.
  task automatic send_random_command();
    int          roll;
    int          hi;
    logic [2:0]  cmd;
    logic [14:0] pg;
    roll = $urandom_range(0, 99);
    hi   = managed_pages() + 2;
    if (hi > 32767) hi = 32767;
    if (roll < 40)      cmd = CMD_ALLOC;
    else if (roll < 55) cmd = CMD_RELEASE;
    else if (roll < 70) cmd = CMD_MARK;
    else if (roll < 96) cmd = CMD_QUERY;
    else if (roll < 97) cmd = CMD_CLEAR;
    else                cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    if ($urandom_range(0, 7) == 0) pg = 15'($urandom);
    else                           pg = 15'($urandom_range(0, hi));
    send_command(cmd, pg);
  endtask

  // Reset state: empty map, full count, pointer at page zero.
  task automatic test_reset_state();
    send_command(CMD_QUERY, 15'h7FFF);
    send_command(CMD_ALLOC, 15'd0);
    send_command(CMD_RELEASE, 15'd0);
  endtask

  // Marking a used page or releasing a clear one leaves the count alone.
  task automatic test_single_page_ops();
    send_command(CMD_MARK, 15'd5);
    send_command(CMD_MARK, 15'd5);
    send_command(CMD_RELEASE, 15'd9);
    send_command(CMD_QUERY, 15'd5);
    send_command(CMD_RELEASE, 15'd5);
  endtask

  // A small map runs out of pages, then a release makes one available again.
  task automatic test_out_of_memory();
    write_total(16'd4);
    send_command(CMD_CLEAR, 15'h7FFF);
    repeat (5) send_command(CMD_ALLOC, 15'($urandom));
    send_command(CMD_RELEASE, 15'd2);
    send_command(CMD_ALLOC, 15'd0);
  endtask

  // Page total of zero, above the map size, and a count driven into saturation.
  task automatic test_total_extremes();
    write_total(16'd0);
    send_command(CMD_ALLOC, 15'd0);
    send_command(CMD_QUERY, 15'd0);
    send_command(CMD_UNUSED_HI, 15'h7FFF);
    write_total(16'hFFFF);
    send_command(CMD_CLEAR, 15'd0);
    send_command(CMD_MARK, 15'h7FFF);
    write_total(16'd1);
    send_command(CMD_CLEAR, 15'd0);
    send_command(CMD_ALLOC, 15'd0);
    write_total(16'd16);
    send_command(CMD_MARK, 15'd9);
  endtask

  // Random phases under a range of page totals; some keep a stale count.
  task automatic test_random_traffic();
    logic [15:0] totals [9];
    totals = '{16'd64, 16'd32768, 16'd1, 16'd65535, 16'd200, 16'd0, 16'd8,
               16'd1000, 16'd37};
    foreach (totals[i]) begin
      write_total(totals[i]);
      if ($urandom_range(0, 3) != 0) send_command(CMD_CLEAR, 15'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_command();
        // Now and then hold off until every result is back.
        if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) wait_drained();
      end
    end
  endtask

  // Last stretch with no idling on either side.
  task automatic test_back_to_back();
    write_total(16'd128);
    idle_on = 1'b0;
    send_command(CMD_CLEAR, 15'd0);
    repeat (60) send_random_command();
  endtask

  initial begin
    page_map        = '{default: 1'b0};
    total_pages_reg = RST_TOTAL;
    free_page_count = 16'(managed_pages());
    first_free_page = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_single_page_ops();
    test_out_of_memory();
    test_total_extremes();
    test_random_traffic();
    test_back_to_back();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
